>>> design/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants for the position and PnL tracker.
// ----------------------------------------------------------------------------
package ppt_pkg;
    localparam int NUM_SYMBOLS_DEF = 64;

    localparam logic [2:0] OP_TRADE   = 3'd0;
    localparam logic [2:0] OP_CLOSE   = 3'd1;
    localparam logic [2:0] OP_PARTIAL = 3'd2;
    localparam logic [2:0] OP_MARK    = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOPOS   = 2'd1;
    localparam logic [1:0] ST_SAMESIDE = 2'd2;

    // datapath commands from the controller
    typedef struct packed {
        logic load;      // capture input item
        logic rd;        // issue entry read
        logic eval;      // evaluate the operation
        logic div_go;    // start divider
        logic wb;        // write entry back and form result
        logic clr;       // clear pass step
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic clr_last;
    } t_sts;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else sat_add = s[63:0];
    endfunction
endpackage

>>> design/ppt_ram.sv
// ----------------------------------------------------------------------------
// ppt_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/ppt_div.sv
// ----------------------------------------------------------------------------
// ppt_div
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_trial;
    logic [33:0] n_shift;

    always_comb begin
        n_shift = {r_rem, r_q[63]};
        n_trial = n_shift[32:0] - {1'b0, r_den};
    end

    // one bit per cycle until all 64 quotient bits are formed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                if (n_shift[33] || !n_trial[32]) begin
                    r_rem <= n_shift[33] ? n_shift[32:0] - {1'b0, r_den} : n_trial;
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift[32:0];
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_q;
endmodule

>>> design/ppt_ctrl.sv
// ----------------------------------------------------------------------------
// ppt_ctrl
// Sequencer for one item: read, evaluate, optional divide, write back, output; or clear pass, output.
// ----------------------------------------------------------------------------
module ppt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_op,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ppt_pkg::t_cmd o_cmd,
    input  ppt_pkg::t_sts i_sts
);
    import ppt_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_DIV, S_WB, S_CLR, S_OUT} t_state;
    t_state r_state;
    logic   r_clr_init;

    assign o_in_ready = (r_state == S_IDLE) && !r_clr_init;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = i_in_valid && o_in_ready;
        o_cmd.rd     = (r_state == S_READ);
        o_cmd.eval   = (r_state == S_EVAL);
        o_cmd.div_go = (r_state == S_EVAL) && i_sts.need_div;
        o_cmd.wb     = (r_state == S_WB);
        o_cmd.clr    = (r_state == S_CLR) || r_clr_init;
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_clr_init  <= 1'b1;
        end else begin
            if (r_clr_init && i_sts.clr_last) r_clr_init <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_cmd.load) r_state <= (i_op == OP_CLEAR) ? S_CLR : S_READ;
                S_READ: r_state <= S_EVAL;
                S_EVAL: r_state <= i_sts.need_div ? S_DIV : S_WB;
                S_DIV:  if (i_sts.div_done) r_state <= S_WB;
                S_WB: begin
                    r_state     <= S_OUT;
                    o_out_valid <= 1'b1;
                end
                S_CLR: if (i_sts.clr_last) begin
                    r_state     <= S_OUT;
                    o_out_valid <= 1'b1;
                end
                S_OUT: if (i_out_ready) begin
                    r_state     <= S_IDLE;
                    o_out_valid <= 1'b0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> design/ppt_dp.sv
// ----------------------------------------------------------------------------
// ppt_dp
// Entry table, cash account and PnL arithmetic.
// ----------------------------------------------------------------------------
module ppt_dp #(
    parameter int NUM_SYMBOLS = ppt_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppt_pkg::t_cmd       i_cmd,
    output ppt_pkg::t_sts       o_sts,
    input  logic signed [63:0]  i_cfg_cash,
    input  logic [2:0]          i_op,
    input  logic [5:0]          i_sym,
    input  logic signed [31:0]  i_qty,
    input  logic [31:0]         i_price,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_held_quantity,
    output logic [31:0]         o_entry_price,
    output logic signed [63:0]  o_open_pnl,
    output logic signed [63:0]  o_closed_pnl,
    output logic signed [63:0]  o_cash_balance
);
    import ppt_pkg::*;

    localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int ROW = 32 + 32 + 64 + 64;

    logic [2:0]         r_op;
    logic [5:0]         r_sym;
    logic signed [31:0] r_q;
    logic [31:0]        r_px;
    logic               r_inr;
    logic signed [63:0] r_cash;
    logic [AW-1:0]      r_clr_addr;
    logic [NUM_SYMBOLS-1:0] r_valid;

    // entry row: qty, avg, unrealized, realized (mark and valid kept apart)
    logic [ROW-1:0] rd_row, wr_row;
    logic           wr_en;
    logic [AW-1:0]  wr_addr, idx;
    logic [31:0]    mark_rd;

    // evaluated values
    logic signed [31:0] r_nq;
    logic [31:0]        r_navg, r_nmark;
    logic signed [63:0] r_nunr, r_nreal, r_ncash;
    logic               r_nvalid, r_wmark, r_wrow;
    logic [1:0]         r_st;

    logic        div_done;
    logic [63:0] quo;

    logic signed [31:0] p;
    logic [31:0]        pa;
    logic signed [63:0] preal, punr;
    logic               pv;

    // evaluation terms
    logic signed [32:0] e_t, e_diff, e_c, e_k, e_m;
    logic signed [31:0] e_tsat;
    logic [31:0]        e_pm, e_qm, e_cq, e_den;
    logic [63:0]        e_num;
    logic signed [65:0] e_pnl66, e_cash66;
    logic signed [63:0] e_pnl, e_cashd;
    logic               e_need_div;

    assign idx = AW'(r_sym);
    assign p     = rd_row[ROW-1 -: 32];
    assign pa    = rd_row[ROW-33 -: 32];
    assign punr  = rd_row[127:64];
    assign preal = rd_row[63:0];
    assign pv    = r_valid[idx];

    ppt_ram #(.WIDTH(ROW), .DEPTH(NUM_SYMBOLS)) u_row (
        .i_clk(i_clk), .i_we(wr_en), .i_waddr(wr_addr), .i_wdata(wr_row),
        .i_raddr(idx), .o_rdata(rd_row));

    ppt_ram #(.WIDTH(32), .DEPTH(NUM_SYMBOLS)) u_mark (
        .i_clk(i_clk), .i_we(wr_en && (r_wmark || i_cmd.clr)), .i_waddr(wr_addr),
        .i_wdata(i_cmd.clr ? 32'd0 : r_nmark), .i_raddr(idx), .o_rdata(mark_rd));

    ppt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_go),
        .i_num(e_num), .i_den(e_den), .o_done(div_done), .o_quo(quo));

    assign o_sts.need_div = e_need_div;
    assign o_sts.div_done = div_done;
    assign o_sts.clr_last = (r_clr_addr == AW'(NUM_SYMBOLS - 1));

    assign wr_en   = i_cmd.clr || (i_cmd.wb && r_wrow && r_inr);
    assign wr_addr = i_cmd.clr ? r_clr_addr : idx;
    assign wr_row  = i_cmd.clr ? '0 : {r_nq, r_navg, r_nunr, r_nreal};

    // operands and products for one operation on the fetched entry
    always_comb begin
        e_diff = $signed({1'b0, r_px}) - $signed({1'b0, pa});
        e_t    = $signed({p[31], p}) + $signed({r_q[31], r_q});
        if (e_t[32] != e_t[31]) e_tsat = e_t[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else e_tsat = e_t[31:0];
        e_pm = p[31] ? $unsigned(-p) : $unsigned(p);
        e_qm = r_q[31] ? $unsigned(-r_q) : $unsigned(r_q);
        e_cq = (e_qm < e_pm) ? e_qm : e_pm;
        e_c  = p[31] ? -$signed({1'b0, e_cq}) : $signed({1'b0, e_cq});
        // pnl quantity: whole position for close and mark, closed part otherwise
        e_k  = (r_op == OP_CLOSE || r_op == OP_MARK) ? $signed({p[31], p}) : e_c;
        // cash quantity: minus traded qty for trade, position for close, closed part otherwise
        if (r_op == OP_TRADE) e_m = -$signed({r_q[31], r_q});
        else if (r_op == OP_CLOSE) e_m = $signed({p[31], p});
        else e_m = e_c;
        e_pnl66  = e_diff * e_k;
        e_cash66 = e_m * $signed({1'b0, r_px});
        e_pnl    = e_pnl66[63:0];
        e_cashd  = e_cash66[63:0];
        e_num    = pa * e_pm + r_px * e_qm;
        e_den    = e_tsat[31] ? $unsigned(-e_tsat) : $unsigned(e_tsat);
        e_need_div = (r_op == OP_TRADE) && r_inr && (r_q != 0) && pv
                     && (p[31] == r_q[31]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_cash     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + AW'(1);
                r_valid    <= '0;
                r_cash     <= i_cfg_cash;
            end
            if (i_cmd.wb && r_inr) r_valid[idx] <= r_nvalid;
            if (i_cmd.wb) r_cash <= r_ncash;
        end
    end

    // item capture, evaluation and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_sym <= i_sym;
            r_q   <= i_qty;
            r_px  <= i_price;
            r_inr <= 32'(i_sym) < NUM_SYMBOLS;
        end
        if (i_cmd.eval) begin
            r_nq <= p; r_navg <= pa; r_nmark <= mark_rd; r_nunr <= punr;
            r_nreal <= r_inr ? preal : '0; r_nvalid <= pv && r_inr; r_ncash <= r_cash;
            r_wmark <= 1'b0; r_wrow <= 1'b0; r_st <= ST_DONE;
            if (!r_inr && r_op <= OP_MARK) begin
                r_st <= ST_NOPOS; r_nvalid <= 1'b0;
            end else begin
                unique case (r_op)
                    OP_TRADE: if (r_q != 0) begin
                        r_ncash <= sat_add(r_cash, e_cashd);
                        r_wrow  <= 1'b1;
                        if (!pv) begin
                            r_nvalid <= 1'b1; r_nq <= r_q; r_navg <= r_px;
                            r_nmark <= r_px; r_wmark <= 1'b1; r_nunr <= '0;
                        end else if (p[31] == r_q[31]) begin
                            r_nq <= e_tsat;
                        end else begin
                            r_nreal <= sat_add(preal, e_pnl);
                            if (e_t == 33'sd0) r_nvalid <= 1'b0;
                            else begin
                                r_nq <= e_t[31:0];
                                if (e_t[32] != p[31]) r_navg <= r_px;
                            end
                        end
                    end
                    OP_CLOSE: if (!pv) r_st <= ST_NOPOS;
                    else begin
                        r_nreal <= sat_add(preal, e_pnl);
                        r_ncash <= sat_add(r_cash, e_cashd);
                        r_nvalid <= 1'b0; r_wrow <= 1'b1;
                    end
                    OP_PARTIAL: if (!pv) r_st <= ST_NOPOS;
                    else if (r_q == 0 || p[31] == r_q[31]) r_st <= ST_SAMESIDE;
                    else begin
                        r_nreal <= sat_add(preal, e_pnl);
                        r_ncash <= sat_add(r_cash, e_cashd);
                        r_wrow <= 1'b1;
                        if (e_c == $signed({p[31], p})) r_nvalid <= 1'b0;
                        else r_nq <= p - e_c[31:0];
                    end
                    OP_MARK: if (!pv) r_st <= ST_NOPOS;
                    else begin
                        r_nmark <= r_px; r_wmark <= 1'b1; r_wrow <= 1'b1;
                        r_nunr  <= e_pnl;
                    end
                    default: ;
                endcase
            end
        end
        if (div_done) r_navg <= (quo > 64'hffffffff) ? 32'hffffffff : quo[31:0];
        if (i_cmd.wb) begin
            o_status        <= r_st;
            o_held_quantity <= r_nvalid ? r_nq : '0;
            o_entry_price   <= r_nvalid ? r_navg : '0;
            o_open_pnl      <= r_nvalid ? r_nunr : '0;
            o_closed_pnl    <= r_inr ? r_nreal : '0;
            o_cash_balance  <= r_ncash;
        end else if (i_cmd.clr && o_sts.clr_last) begin
            o_status <= ST_DONE; o_held_quantity <= '0; o_entry_price <= '0;
            o_open_pnl <= '0; o_closed_pnl <= '0; o_cash_balance <= i_cfg_cash;
        end
    end
endmodule

>>> design/position_pnl_tracker_top.sv
// ----------------------------------------------------------------------------
// position_pnl_tracker_top
// Per-symbol average-cost position and PnL table with one cash account.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  input    | i_in_valid/o_in_ready  | operation, symbol_index, quantity, price
//  result   | o_out_valid/i_out_ready| status, quantity, price, pnl, cash
//  config   | i_cfg_we               | i_cfg_data (initial cash)
//
// An item passes through read, evaluate, an optional divide for a same-side
// trade, write back and output, where it waits for i_out_ready. Clear sweeps
// every table entry. After reset a clearing pass runs before ready rises.
// One item at a time; a stalled result holds the block.
module position_pnl_tracker_top #(
    parameter int NUM_SYMBOLS = ppt_pkg::NUM_SYMBOLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [63:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_operation,
    input  logic [5:0]         i_symbol_index,
    input  logic signed [31:0] i_quantity,
    input  logic [31:0]        i_price,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_held_quantity,
    output logic [31:0]        o_entry_price,
    output logic signed [63:0] o_open_pnl,
    output logic signed [63:0] o_closed_pnl,
    output logic signed [63:0] o_cash_balance
);
    import ppt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic signed [63:0] r_init_cash;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_init_cash <= '0;
        else if (i_cfg_we) r_init_cash <= i_cfg_data;
    end

    ppt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_op(i_operation), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_cmd(cmd), .i_sts(sts));

    ppt_dp #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_cfg_cash(r_init_cash), .i_op(i_operation), .i_sym(i_symbol_index),
        .i_qty(i_quantity), .i_price(i_price), .o_status(o_status),
        .o_held_quantity(o_held_quantity), .o_entry_price(o_entry_price),
        .o_open_pnl(o_open_pnl), .o_closed_pnl(o_closed_pnl),
        .o_cash_balance(o_cash_balance));
endmodule

>>> design/ppt_checker.sv
// ----------------------------------------------------------------------------
// ppt_checker
// Port-level checks for the position and PnL tracker.
// ----------------------------------------------------------------------------
module ppt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic [31:0] o_held_quantity
);
    // no new item while a result is pending
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("ready with result pending");
    // an accepted item is not followed by a result in the next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid) else $error("result too soon");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_status)
        && $stable(o_held_quantity)) else $error("result dropped");
    // status codes stay in range
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3) else $error("bad status");
endmodule

bind position_pnl_tracker_top ppt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_status(o_status), .o_held_quantity(o_held_quantity));
